[rtl/core/tsqs_pkg.sv]
// Shared constants, types and helpers for the time slot scheduler.
package tsqs_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
   localparam int LINK_BITS  = SLOT_BITS + 1;
   localparam int OWNER_BITS = 16;
   localparam int TICK_BITS  = 16;
   localparam int CMD_BITS   = 3;
   localparam int STAT_BITS  = 2;
   localparam int CSR_BITS   = 1;

   localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(SLOT_COUNT);
   localparam logic [SLOT_BITS-1:0] TOP_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

   localparam logic [CMD_BITS-1:0] CMD_ALLOC_ANY  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_ALLOC_SLOT = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_SET_OWNER  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_FREE_SLOT  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_TICK       = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_NEXT       = 3'd5;

   localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_BUSY      = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_NOT_ALLOC = 2'd2;

   localparam logic [CSR_BITS-1:0] CSR_BASE_TICKS = 1'd0;
   localparam logic [CSR_BITS-1:0] CSR_TICK_CAP   = 1'd1;

   typedef struct packed {
      logic [LINK_BITS-1:0] next;
      logic [LINK_BITS-1:0] prev;
   } link_type;

   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic [TICK_BITS-1:0]  ticks;
   } slot_entry_type;

   function automatic link_type link_reset(input logic [SLOT_BITS-1:0] idx);
      link_type l;
      l.next = (idx == '0) ? NIL_LINK : LINK_BITS'(idx) - LINK_BITS'(1);
      l.prev = (idx == TOP_SLOT) ? NIL_LINK : LINK_BITS'(idx) + LINK_BITS'(1);
      return l;
   endfunction

endpackage

[rtl/core/time_slot_quantum_scheduler.sv]
// Time slot scheduler: slot table and free list in memories, command sequencer.
//
//  channel | ports          | word
//  --------+----------------+---------------------------------------------
//  request | req_t*         | command, slot, owner
//  result  | rsp_t*         | status, slot_out, owner_out, expired, idle
//  config  | csr_*          | grant_ticks (index 0), tick_cap (index 1)
//
// One word at a time. next makes pipelined passes of the slot memory, one slot a
// cycle: a scan up from the current slot and, if it finds none, a refill pass of
// every slot and a scan on from slot 1 up to the current slot.
// Reset is synchronous; valid bits stand in for the reset of both memories.
// A result waits in the output register; a stalled result holds the sequencer.
module time_slot_quantum_scheduler
   import tsqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // command[2:0], slot[8:3], owner[24:9]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // status[1:0], slot_out[7:2],
                                              // owner_out[23:8], expired[24], idle[25]
   input  logic                  csr_we,
   input  logic [CSR_BITS-1:0]   csr_addr,
   input  logic [TICK_BITS-1:0]  csr_wdata
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_TAKE   = 11'b00000000010,
      S_RM_P   = 11'b00000000100,
      S_RM_N   = 11'b00000001000,
      S_OWN    = 11'b00000010000,
      S_TICK   = 11'b00000100000,
      S_PUSH   = 11'b00001000000,
      S_SCAN   = 11'b00010000000,
      S_REFILL = 11'b00100000000,
      S_DONE   = 11'b01000000000,
      S_SPARE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [TICK_BITS-1:0]  base_ff, cap_ff;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [SLOT_COUNT-1:0] lk_ok_ff, lk_ok_in;
   logic [LINK_BITS-1:0]  head_ff, head_in;
   logic [SLOT_BITS-1:0]  cur_ff, cur_in;
   logic [SLOT_BITS-1:0]  target_ff, target_in;
   logic [LINK_BITS-1:0]  aux_ff, aux_in;
   logic [LINK_BITS-1:0]  lp_ff, lp_in, ln_ff, ln_in;
   logic [OWNER_BITS-1:0] own_ff, own_in;
   logic [SLOT_BITS-1:0]  scan_ff, scan_in, last_ff, last_in;
   logic                  pend_ff, pend_in, phb_ff, phb_in;

   logic [STAT_BITS-1:0]  rst_ff, rst_in;
   logic [SLOT_BITS-1:0]  rslot_ff, rslot_in;
   logic [OWNER_BITS-1:0] rown_ff, rown_in;
   logic                  rexp_ff, rexp_in, ridle_ff, ridle_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;

   link_type              lk_mem [SLOT_COUNT];
   link_type              lk_q_ff, lk_rd, lk_wdata;
   logic [SLOT_BITS-1:0]  lk_raddr, lk_raddr_ff, lk_waddr;
   logic                  lk_re, lk_we;

   slot_entry_type        sm_mem [SLOT_COUNT];
   slot_entry_type        sm_q_ff, sm_rd, sm_wdata;
   logic [SLOT_BITS-1:0]  sm_raddr, sm_raddr_ff, sm_waddr;
   logic                  sm_re, sm_we;

   logic [CMD_BITS-1:0]   in_cmd;
   logic [SLOT_BITS-1:0]  in_slot;
   logic [OWNER_BITS-1:0] in_owner;
   logic                  elig, scan_end;
   logic [TICK_BITS:0]    sum;
   logic [TICK_BITS-1:0]  refill_t, tick_t;

   assign in_cmd   = req_tdata[2:0];
   assign in_slot  = req_tdata[8:3];
   assign in_owner = req_tdata[24:9];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign lk_rd = lk_ok_ff[lk_raddr_ff] ? lk_q_ff : link_reset(lk_raddr_ff);
   assign sm_rd = used_ff[sm_raddr_ff] ? sm_q_ff : '0;

   assign elig     = pend_ff && (sm_rd.owner != '0) && (sm_rd.ticks != '0)
                     && used_ff[sm_raddr_ff];
   assign scan_end = pend_ff && (sm_raddr_ff == last_ff);
   assign sum      = {1'b0, sm_rd.ticks} + {1'b0, base_ff};
   assign refill_t = (sum > {1'b0, cap_ff}) ? cap_ff : sum[TICK_BITS-1:0];
   assign tick_t   = (sm_rd.ticks > TICK_BITS'(1)) ? sm_rd.ticks - TICK_BITS'(1) : '0;

   always_ff @(posedge clock) begin
      if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
      if (lk_re) begin
         lk_q_ff     <= lk_mem[lk_raddr];
         lk_raddr_ff <= lk_raddr;
      end
      if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
      if (sm_re) begin
         sm_q_ff     <= sm_mem[sm_raddr];
         sm_raddr_ff <= sm_raddr;
      end
   end

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      lk_ok_in  = lk_ok_ff;
      head_in   = head_ff;
      cur_in    = cur_ff;
      target_in = target_ff;
      aux_in    = aux_ff;
      lp_in     = lp_ff;
      ln_in     = ln_ff;
      own_in    = own_ff;
      scan_in   = scan_ff;
      last_in   = last_ff;
      pend_in   = pend_ff;
      phb_in    = phb_ff;
      rst_in    = rst_ff;
      rslot_in  = rslot_ff;
      rown_in   = rown_ff;
      rexp_in   = rexp_ff;
      ridle_in  = ridle_ff;
      lk_re = 1'b0; lk_raddr = '0; lk_we = 1'b0; lk_waddr = '0; lk_wdata = '0;
      sm_re = 1'b0; sm_raddr = '0; sm_we = 1'b0; sm_waddr = '0; sm_wdata = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rst_in   = STAT_OK;
               rslot_in = cur_ff;
               rown_in  = '0;
               rexp_in  = 1'b0;
               ridle_in = 1'b0;
               own_in   = in_owner;
               target_in = in_slot;
               state_in = S_DONE;
               case (in_cmd)
                  CMD_ALLOC_ANY: begin
                     if (head_ff == NIL_LINK) begin
                        rst_in = STAT_BUSY;
                     end else begin
                        target_in = head_ff[SLOT_BITS-1:0];
                        lk_re     = 1'b1;
                        lk_raddr  = head_ff[SLOT_BITS-1:0];
                        state_in  = S_TAKE;
                     end
                  end
                  CMD_ALLOC_SLOT: begin
                     if (used_ff[in_slot]) begin
                        rst_in = STAT_BUSY;
                     end else begin
                        lk_re    = 1'b1;
                        lk_raddr = in_slot;
                        state_in = S_TAKE;
                     end
                  end
                  CMD_SET_OWNER: begin
                     if (!used_ff[in_slot]) begin
                        rst_in = STAT_NOT_ALLOC;
                     end else begin
                        sm_re    = 1'b1;
                        sm_raddr = in_slot;
                        state_in = S_OWN;
                     end
                  end
                  CMD_FREE_SLOT: begin
                     if (!used_ff[in_slot]) begin
                        rst_in = STAT_NOT_ALLOC;
                     end else begin
                        used_in[in_slot]  = 1'b0;
                        sm_we             = 1'b1;
                        sm_waddr          = in_slot;
                        sm_wdata          = '0;
                        lk_we             = 1'b1;
                        lk_waddr          = in_slot;
                        lk_wdata.next     = head_ff;
                        lk_wdata.prev     = NIL_LINK;
                        lk_ok_in[in_slot] = 1'b1;
                        head_in           = {1'b0, in_slot};
                        aux_in            = head_ff;
                        if (head_ff != NIL_LINK) begin
                           lk_re    = 1'b1;
                           lk_raddr = head_ff[SLOT_BITS-1:0];
                           state_in = S_PUSH;
                        end
                     end
                  end
                  CMD_TICK: begin
                     sm_re    = 1'b1;
                     sm_raddr = cur_ff;
                     state_in = S_TICK;
                  end
                  CMD_NEXT: begin
                     pend_in = 1'b0;
                     phb_in  = 1'b0;
                     last_in = TOP_SLOT;
                     if (cur_ff == TOP_SLOT) begin
                        scan_in  = '0;
                        state_in = S_REFILL;
                     end else begin
                        scan_in  = cur_ff + SLOT_BITS'(1);
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_TAKE: begin
            used_in[target_ff] = 1'b1;
            sm_we          = 1'b1;
            sm_waddr       = target_ff;
            sm_wdata.owner = own_ff;
            sm_wdata.ticks = base_ff;
            rslot_in       = target_ff;
            lp_in          = lk_rd.prev;
            ln_in          = lk_rd.next;
            if (lk_rd.prev != NIL_LINK) begin
               lk_re    = 1'b1;
               lk_raddr = lk_rd.prev[SLOT_BITS-1:0];
               state_in = S_RM_P;
            end else begin
               head_in = lk_rd.next;
               if (lk_rd.next != NIL_LINK) begin
                  lk_re    = 1'b1;
                  lk_raddr = lk_rd.next[SLOT_BITS-1:0];
                  state_in = S_RM_N;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_RM_P: begin
            lk_we         = 1'b1;
            lk_waddr      = lp_ff[SLOT_BITS-1:0];
            lk_wdata.next = ln_ff;
            lk_wdata.prev = lk_rd.prev;
            lk_ok_in[lp_ff[SLOT_BITS-1:0]] = 1'b1;
            if (ln_ff != NIL_LINK) begin
               lk_re    = 1'b1;
               lk_raddr = ln_ff[SLOT_BITS-1:0];
               state_in = S_RM_N;
            end else begin
               state_in = S_DONE;
            end
         end

         S_RM_N: begin
            lk_we         = 1'b1;
            lk_waddr      = ln_ff[SLOT_BITS-1:0];
            lk_wdata.next = lk_rd.next;
            lk_wdata.prev = lp_ff;
            lk_ok_in[ln_ff[SLOT_BITS-1:0]] = 1'b1;
            state_in      = S_DONE;
         end

         S_PUSH: begin
            lk_we         = 1'b1;
            lk_waddr      = aux_ff[SLOT_BITS-1:0];
            lk_wdata.next = lk_rd.next;
            lk_wdata.prev = {1'b0, target_ff};
            lk_ok_in[aux_ff[SLOT_BITS-1:0]] = 1'b1;
            state_in      = S_DONE;
         end

         S_OWN: begin
            sm_we          = 1'b1;
            sm_waddr       = target_ff;
            sm_wdata.owner = own_ff;
            sm_wdata.ticks = sm_rd.ticks;
            state_in       = S_DONE;
         end

         S_TICK: begin
            sm_we          = 1'b1;
            sm_waddr       = cur_ff;
            sm_wdata.owner = sm_rd.owner;
            sm_wdata.ticks = tick_t;
            rexp_in        = (tick_t == '0);
            state_in       = S_DONE;
         end

         S_SCAN: begin
            if (elig) begin
               cur_in   = sm_raddr_ff;
               rslot_in = sm_raddr_ff;
               rown_in  = sm_rd.owner;
               state_in = S_DONE;
            end else if (scan_end) begin
               pend_in = 1'b0;
               if (phb_ff) begin
                  ridle_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  scan_in  = '0;
                  last_in  = TOP_SLOT;
                  state_in = S_REFILL;
               end
            end else begin
               sm_re    = 1'b1;
               sm_raddr = scan_ff;
               scan_in  = scan_ff + SLOT_BITS'(1);
               pend_in  = 1'b1;
            end
         end

         S_REFILL: begin
            if (pend_ff && used_ff[sm_raddr_ff]) begin
               sm_we          = 1'b1;
               sm_waddr       = sm_raddr_ff;
               sm_wdata.owner = sm_rd.owner;
               sm_wdata.ticks = refill_t;
            end
            if (scan_end) begin
               pend_in  = 1'b0;
               phb_in   = 1'b1;
               scan_in  = SLOT_BITS'(1);
               last_in  = cur_ff;
               state_in = S_SCAN;
            end else begin
               sm_re    = 1'b1;
               sm_raddr = scan_ff;
               scan_in  = scan_ff + SLOT_BITS'(1);
               pend_in  = 1'b1;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, ridle_ff, rexp_ff, rown_ff, rslot_ff, rst_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= TICK_BITS'(4);
         cap_ff       <= '1;
         used_ff      <= '0;
         lk_ok_ff     <= '0;
         head_ff      <= {1'b0, TOP_SLOT};
         cur_ff       <= SLOT_BITS'(1);
         pend_ff      <= 1'b0;
         phb_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         lk_ok_ff     <= lk_ok_in;
         head_ff      <= head_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         phb_ff       <= phb_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BASE_TICKS: base_ff <= csr_wdata;
               CSR_TICK_CAP:   cap_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      aux_ff      <= aux_in;
      lp_ff       <= lp_in;
      ln_ff       <= ln_in;
      own_ff      <= own_in;
      scan_ff     <= scan_in;
      last_ff     <= last_in;
      rst_ff      <= rst_in;
      rslot_ff    <= rslot_in;
      rown_ff     <= rown_in;
      rexp_ff     <= rexp_in;
      ridle_ff    <= ridle_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
